/* rtl/core/fcms_pkg.sv */
// ----------------------------------------------------------------------------
// fcms_pkg
// Constants, types and hash helpers of the flow count-min sketch update block.
// ----------------------------------------------------------------------------
package fcms_pkg;

  localparam int unsigned Buckets   = 4096;
  localparam int unsigned BucketW   = $clog2(Buckets);
  localparam int unsigned CountW    = 32;
  localparam logic [31:0] Pr1       = 32'h9E37_79B1;
  localparam logic [31:0] Pr2       = 32'h85EB_CA77;
  localparam logic [31:0] Pr3       = 32'hC2B2_AE3D;
  localparam logic [31:0] Pr4       = 32'h27D4_EB2F;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [31:0] TupleLen  = 32'd20;
  localparam logic [31:0] SeedReset = 32'd42;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LANE_MUL,   // word * PR2 for four lanes, w4 * PR3
    ST_LANE_ROT,   // acc + product, rotate, * PR1
    ST_MERGE,      // merge lanes, add length and tail product
    ST_TAIL,       // rotate 17, * PR4
    ST_AV1,        // xor-shift 15, * PR2
    ST_AV2,        // xor-shift 13, * PR3
    ST_AV3,        // xor-shift 16, issue memory read
    ST_RMW,        // read data back, increment, write
    ST_OUT         // result waits for the sink
  } fcms_state_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (32 - r));
  endfunction

endpackage

/* rtl/core/fcms_ram.sv */
// ----------------------------------------------------------------------------
// fcms_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module fcms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/core/flow_count_min_sketch_update.sv */
// ----------------------------------------------------------------------------
// flow_count_min_sketch_update
// XXH32 of the TCP/IPv4 five-tuple selects a 32-bit counter in a one-row
// count-min store, which is incremented; one result item per input item.
// ----------------------------------------------------------------------------
// After reset the block sweeps the counter memory to zero, one entry a cycle,
// and takes no item meanwhile; seed writes are taken at any time. An item
// that is not IPv4/TCP goes from acceptance straight to ST_OUT, all-zero.
// A counted item passes from the accepting cycle through the hash-round
// states LANE_MUL, LANE_ROT, MERGE, TAIL, AV1, AV2 and AV3, with at most one
// registered 32x32 multiply per lane in each, the last of them issuing the
// memory read, then RMW (read-back with write) and OUT. One item is in flight,
// so the read-modify-write never overlaps another access to the store.
module flow_count_min_sketch_update
  import fcms_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                is_ipv4_i,
  input  logic [7:0]          protocol_i,
  input  logic [31:0]         src_addr_i,
  input  logic [31:0]         dst_addr_i,
  input  logic [15:0]         sport_i,
  input  logic [15:0]         dport_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                counted_o,
  output logic [31:0]         flow_hash_o,
  output logic [11:0]         bucket_o,
  output logic [CountW-1:0]   new_count_o
);

  fcms_state_e state_q, state_d;
  logic [31:0] seed_q;
  logic        clr_q;
  logic [BucketW:0] clr_cnt_q;
  logic [31:0] w_q [5];
  logic [31:0] a_q [4];
  logic [31:0] p_q [4];
  logic [31:0] t_q, h_q;
  logic [31:0] h_fin;
  logic        counted_q;
  logic [CountW-1:0] cnt_q;
  logic        accept;
  logic        counted_in;

  logic                 ram_we;
  logic [BucketW-1:0]   ram_addr;
  logic [CountW-1:0]    ram_wdata, ram_rdata;
  logic [BucketW-1:0]   bkt;

  // final avalanche step, so the read can be issued in the same cycle
  assign h_fin      = h_q ^ (h_q >> 16);
  assign bkt        = (state_q == ST_AV3) ? h_fin[BucketW-1:0] : h_q[BucketW-1:0];
  assign counted_in = is_ipv4_i && (protocol_i == ProtoTcp);
  assign in_stall_o = clr_q || (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = bkt;
    ram_wdata = ram_rdata + CountW'(1);
    if (clr_q) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q[BucketW-1:0];
      ram_wdata = '0;
    end else if (state_q == ST_RMW) begin
      ram_we = 1'b1;
    end
  end

  fcms_ram #(.Width(CountW), .Depth(Buckets)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept) state_d = counted_in ? ST_LANE_MUL : ST_OUT;
      ST_LANE_MUL: state_d = ST_LANE_ROT;
      ST_LANE_ROT: state_d = ST_MERGE;
      ST_MERGE:    state_d = ST_TAIL;
      ST_TAIL:     state_d = ST_AV1;
      ST_AV1:      state_d = ST_AV2;
      ST_AV2:      state_d = ST_AV3;
      ST_AV3:      state_d = ST_RMW;
      ST_RMW:      state_d = ST_OUT;
      ST_OUT:      if (!out_stall_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      seed_q    <= SeedReset;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == (BucketW+1)'(Buckets - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // datapath, at most one multiply per lane in each state
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (accept) begin
        counted_q <= counted_in;
        w_q[0] <= src_addr_i;
        w_q[1] <= dst_addr_i;
        w_q[2] <= {24'd0, protocol_i};
        w_q[3] <= {16'd0, sport_i};
        w_q[4] <= {16'd0, dport_i};
        a_q[0] <= seed_q + Pr1 + Pr2;
        a_q[1] <= seed_q + Pr2;
        a_q[2] <= seed_q;
        a_q[3] <= seed_q - Pr1;
        h_q    <= '0;
        cnt_q  <= '0;
      end
      ST_LANE_MUL: begin
        for (int i = 0; i < 4; i++) p_q[i] <= w_q[i] * Pr2;
        t_q <= w_q[4] * Pr3;
      end
      ST_LANE_ROT: begin
        for (int i = 0; i < 4; i++) a_q[i] <= rotl(a_q[i] + p_q[i], 13) * Pr1;
      end
      ST_MERGE: h_q <= rotl(a_q[0], 1) + rotl(a_q[1], 7) + rotl(a_q[2], 12)
                       + rotl(a_q[3], 18) + TupleLen + t_q;
      ST_TAIL:  h_q <= rotl(h_q, 17) * Pr4;
      ST_AV1:   h_q <= (h_q ^ (h_q >> 15)) * Pr2;
      ST_AV2:   h_q <= (h_q ^ (h_q >> 13)) * Pr3;
      ST_AV3:   h_q <= h_fin;
      ST_RMW:   cnt_q <= ram_rdata + CountW'(1);
      default: ;
    endcase
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign counted_o   = counted_q;
  assign flow_hash_o = h_q;
  assign bucket_o    = 12'(bkt);
  assign new_count_o = cnt_q;

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !accept) else $error("item taken during clear");
  a_out_after_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RMW |=> out_valid_o && counted_o) else $error("rmw not followed by result");
  a_uncounted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !counted_o |-> flow_hash_o == '0 && new_count_o == '0)
    else $error("uncounted result not zero");

endmodule

/* sim/tb_flow_count_min_sketch_update.sv */
// ----------------------------------------------------------------------------
// tb_flow_count_min_sketch_update
// Drives packet tuples with random gaps and sink stalls, predicts each
// result with an independent XXH32/count-min model and compares field by field.
// ----------------------------------------------------------------------------
module tb_flow_count_min_sketch_update
  import fcms_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        is_ipv4;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] sport;
    logic [15:0] dport;
  } pkt_t;

  typedef struct packed {
    logic        counted;
    logic [31:0] flow_hash;
    logic [11:0] bucket;
    logic [31:0] new_count;
  } flow_res_t;

  class flow_sketch_sb;
    logic [31:0] seed;
    logic [31:0] counters [Buckets];
    flow_res_t   pending [$];
    int          errors;
    int          n_checked;
    int          n_counted;

    function new();
      seed = SeedReset;
      foreach (counters[i]) counters[i] = '0;
      errors = 0;
      n_checked = 0;
      n_counted = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function logic [31:0] lane(logic [31:0] acc, logic [31:0] w);
      acc = acc + w * Pr2;
      return rol(acc, 13) * Pr1;
    endfunction

    function logic [31:0] tuple_xxh32(pkt_t p);
      logic [31:0] a1, a2, a3, a4, h;
      a1 = lane(seed + Pr1 + Pr2, p.src_addr);
      a2 = lane(seed + Pr2, p.dst_addr);
      a3 = lane(seed, {24'd0, p.protocol});
      a4 = lane(seed - Pr1, {16'd0, p.sport});
      h = rol(a1, 1) + rol(a2, 7) + rol(a3, 12) + rol(a4, 18) + TupleLen;
      h = h + {16'd0, p.dport} * Pr3;
      h = rol(h, 17) * Pr4;
      h = h ^ (h >> 15);
      h = h * Pr2;
      h = h ^ (h >> 13);
      h = h * Pr3;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function void note_packet(pkt_t p);
      flow_res_t r;
      logic [31:0] h;
      int idx;
      r = '0;
      if (p.is_ipv4 && p.protocol == ProtoTcp) begin
        h = tuple_xxh32(p);
        idx = h % Buckets;
        counters[idx] = counters[idx] + 1;
        r.counted = 1'b1;
        r.flow_hash = h;
        r.bucket = idx[11:0];
        r.new_count = counters[idx];
      end
      pending.push_back(r);
    endfunction

    function void check_result(flow_res_t a);
      flow_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, a);
        errors++;
        return;
      end
      e = pending.pop_front();
      n_checked++;
      if (a.counted) n_counted++;
      if (a.counted !== e.counted) begin
        $display("%0t: counted expected %0d actual %0d", $time, e.counted, a.counted);
        errors++;
      end
      if (a.flow_hash !== e.flow_hash) begin
        $display("%0t: flow_hash expected %h actual %h", $time, e.flow_hash, a.flow_hash);
        errors++;
      end
      if (a.bucket !== e.bucket) begin
        $display("%0t: bucket expected %h actual %h", $time, e.bucket, a.bucket);
        errors++;
      end
      if (a.new_count !== e.new_count) begin
        $display("%0t: new_count expected %h actual %h", $time, e.new_count, a.new_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  pkt_t        pkt = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        counted_o;
  logic [31:0] flow_hash_o;
  logic [11:0] bucket_o;
  logic [31:0] new_count_o;
  bit          sink_idle_ok = 1'b1;

  flow_sketch_sb sb = new();

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  flow_count_min_sketch_update DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o,
    .is_ipv4_i(pkt.is_ipv4), .protocol_i(pkt.protocol),
    .src_addr_i(pkt.src_addr), .dst_addr_i(pkt.dst_addr),
    .sport_i(pkt.sport), .dport_i(pkt.dport),
    .out_valid_o, .out_stall_i,
    .counted_o, .flow_hash_o, .bucket_o, .new_count_o
  );

  // result side: sample at rising edge, change stall at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({counted_o, flow_hash_o, bucket_o, new_count_o});
  end

  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0 || !sink_idle_ok) begin
        out_stall_i <= 1'b0;
      end else begin
        gap = $urandom_range(0, 18);
        if (gap != 0) begin
          out_stall_i <= 1'b1;
          repeat (gap) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
      end
    end
  end

  // returns at the accepting edge; valid stays up until the next item or drain
  task automatic send_packet(pkt_t p, bit idle_first);
    int gap;
    gap = idle_first ? $urandom_range(0, 18) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pkt <= p;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_packet(p);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] s);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.seed = s;
  endtask

  function automatic pkt_t rand_tcp();
    pkt_t p;
    p.is_ipv4 = 1'b1;
    p.protocol = ProtoTcp;
    p.src_addr = $urandom();
    p.dst_addr = $urandom();
    p.sport = 16'($urandom());
    p.dport = 16'($urandom());
    return p;
  endfunction

  // few flows repeated so counters grow and collide
  pkt_t flows [8];

  initial begin
    pkt_t p;
    int k;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, non-counted cases, default seed
    send_packet({1'b1, ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0}, 1'b0);
    send_packet({1'b1, ProtoTcp, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_packet({1'b1, ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0}, 1'b0);
    send_packet({1'b0, ProtoTcp, 32'h12345678, 32'h9ABCDEF0, 16'h1234, 16'h5678}, 1'b0);
    send_packet({1'b1, 8'd17, 32'hC0A80001, 32'h0A000001, 16'd53, 16'd53}, 1'b0);
    send_packet({1'b1, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);
    send_packet({1'b0, 8'h00, 32'h0, 32'h0, 16'h0, 16'h0}, 1'b0);
    send_packet({1'b1, 8'd7, 32'hAAAAAAAA, 32'h55555555, 16'hAAAA, 16'h5555}, 1'b0);
    send_packet({1'b1, ProtoTcp, 32'h55555555, 32'hAAAAAAAA, 16'h5555, 16'hAAAA}, 1'b0);
    for (int i = 0; i < 6; i++)
      send_packet({1'b1, ProtoTcp, 32'hC0A80001, 32'h0A000001, 16'd80, 16'd443}, 1'b1);
    drain();

    write_seed(32'h0);
    send_packet({1'b1, ProtoTcp, 32'h0, 32'h0, 16'h0, 16'h0}, 1'b0);
    send_packet({1'b1, ProtoTcp, 32'hFFFFFFFF, 32'h0, 16'hFFFF, 16'h0}, 1'b1);
    drain();
    write_seed(32'hFFFFFFFF);
    send_packet({1'b1, ProtoTcp, 32'h0, 32'hFFFFFFFF, 16'h0, 16'hFFFF}, 1'b0);
    send_packet({1'b1, ProtoTcp, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF}, 1'b0);

    // sender holds off until everything is back, with the sink free
    sink_idle_ok = 1'b0;
    drain();
    sink_idle_ok = 1'b1;

    // random phases under several seeds
    for (int ph = 0; ph < 4; ph++) begin
      write_seed(ph == 3 ? 32'd42 : $urandom());
      foreach (flows[i]) flows[i] = rand_tcp();
      for (int n = 0; n < 135; n++) begin
        k = $urandom_range(0, 9);
        if (k < 5) p = flows[$urandom_range(0, 7)];
        else if (k < 8) p = rand_tcp();
        else begin
          p = rand_tcp();
          p.is_ipv4 = 1'($urandom());
          p.protocol = 8'($urandom());
        end
        // some stretches without sender gaps
        send_packet(p, (n % 40) >= 10);
      end
      drain();
    end

    $display("tb: %0d results checked, %0d counted, seeds 0, all-ones, default, random",
             sb.n_checked, sb.n_counted);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

endmodule
